// ===== rtl/tmstep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmstep_pkg
// Shared types and constants for the two-symbol Turing machine stepper.
// ----------------------------------------------------------------------------
package tmstep_pkg;

    // tape geometry
    localparam int TAPE_CELLS = 65536;
    localparam int TAPE_AW    = $clog2(TAPE_CELLS);
    localparam int CNT_W      = $clog2(TAPE_CELLS + 1);

    localparam logic [TAPE_AW-1:0] HEAD_LAST  = TAPE_AW'(TAPE_CELLS - 1);
    localparam logic [TAPE_AW-1:0] HEAD_RESET = TAPE_AW'(TAPE_CELLS / 2);

    // port widths
    localparam int STEPS_W = 16;
    localparam int COUNT_W = 17;
    localparam int STATE_W = 3;
    localparam int POS_W   = 16;
    localparam int RULE_W  = 10;
    localparam int CFG_IW  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register map
    localparam int NUM_RULES = 6;
    localparam logic [CFG_IW-1:0] REG_START_STATE = CFG_IW'(6);

    // machine states A..F; codes at or above NUM_RULES freeze the machine
    localparam logic [STATE_W-1:0] MS_A = 3'd0;
    localparam logic [STATE_W-1:0] MS_B = 3'd1;
    localparam logic [STATE_W-1:0] MS_C = 3'd2;
    localparam logic [STATE_W-1:0] MS_D = 3'd3;
    localparam logic [STATE_W-1:0] MS_E = 3'd4;
    localparam logic [STATE_W-1:0] MS_F = 3'd5;

    localparam logic [STATE_W-1:0] START_RESET = MS_A;

    localparam logic [RULE_W-1:0] RULE_RESET [NUM_RULES] =
        '{10'd263, 10'd481, 10'd515, 10'd195, 10'd309, 10'd111};

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DONE
    } seq_state_t;

endpackage

// ===== rtl/two_symbol_turing_machine_stepper.sv =====
`timescale 1ns / 1ps
// A request of n steps runs in SEQ_RUN and shows its result in SEQ_DONE,
// where n counts only the steps run before the machine reaches a frozen state.
// Throughput: one machine step per cycle; a new request is taken only in
// SEQ_IDLE, after the result is taken. The tape RAM does one read each cycle
// and one write each step or clear cycle. After reset the tape RAM is swept
// to zero, one cell a cycle, with req_stall held high; config writes are taken.
// ----------------------------------------------------------------------------
// two_symbol_turing_machine_stepper
// Six-state, two-symbol Turing machine on a ring tape held in a 1-bit RAM.
// ----------------------------------------------------------------------------
module two_symbol_turing_machine_stepper
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [tmstep_pkg::STEPS_W-1:0]      steps,

    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [tmstep_pkg::COUNT_W-1:0]      ones_count,
    output logic [tmstep_pkg::STATE_W-1:0]      machine_state,
    output logic [tmstep_pkg::POS_W-1:0]        head_position,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmstep_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [tmstep_pkg::RULE_W-1:0]       cfg_data
);

    localparam int AW = tmstep_pkg::TAPE_AW;

    tmstep_pkg::seq_state_t seq_reg, seq_next;

    logic [tmstep_pkg::RULE_W-1:0]  rule_reg [tmstep_pkg::NUM_RULES];
    logic [tmstep_pkg::STATE_W-1:0] mstate_reg, mstate_next;
    logic [AW-1:0]                  head_reg, head_next;
    logic [tmstep_pkg::CNT_W-1:0]   ones_reg, ones_next;
    logic [tmstep_pkg::STEPS_W-1:0] remain_reg, remain_next;
    logic [AW-1:0]                  clr_reg;

    // tape RAM
    logic                           tape_mem [tmstep_pkg::TAPE_CELLS];
    logic                           rd_data_reg;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic                           mem_wdata;

    logic                           do_step;
    logic                           state_ok;
    logic [tmstep_pkg::RULE_W-1:0]  rule;
    logic [4:0]                     part;
    logic [AW-1:0]                  head_inc;
    logic [AW-1:0]                  head_dec;
    logic [31:0]                    ones_wide;

    assign cfg_ready = 1'b1;

    assign state_ok = (mstate_reg < tmstep_pkg::STATE_W'(tmstep_pkg::NUM_RULES));

    always_comb
    begin
        unique case (mstate_reg)
            tmstep_pkg::MS_A: rule = rule_reg[0];
            tmstep_pkg::MS_B: rule = rule_reg[1];
            tmstep_pkg::MS_C: rule = rule_reg[2];
            tmstep_pkg::MS_D: rule = rule_reg[3];
            tmstep_pkg::MS_E: rule = rule_reg[4];
            tmstep_pkg::MS_F: rule = rule_reg[5];
            default:          rule = '0;
        endcase
    end

    // once the tape clear is over, rd_data_reg always holds the cell under head_reg
    assign part     = rd_data_reg ? rule[9:5] : rule[4:0];
    assign head_inc = (head_reg == tmstep_pkg::HEAD_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? tmstep_pkg::HEAD_LAST : head_reg - 1'b1;

    always_comb
    begin
        seq_next    = seq_reg;
        do_step     = 1'b0;
        remain_next = remain_reg;
        req_stall   = 1'b1;
        rsp_valid   = 1'b0;

        unique case (seq_reg)
            tmstep_pkg::SEQ_CLEAR:
            begin
                if (clr_reg == tmstep_pkg::HEAD_LAST)
                    seq_next = tmstep_pkg::SEQ_IDLE;
            end
            tmstep_pkg::SEQ_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    remain_next = steps;
                    seq_next    = tmstep_pkg::SEQ_RUN;
                end
            end
            tmstep_pkg::SEQ_RUN:
            begin
                if (remain_reg == '0 || !state_ok)
                    seq_next = tmstep_pkg::SEQ_DONE;
                else
                begin
                    do_step     = 1'b1;
                    remain_next = remain_reg - 1'b1;
                end
            end
            tmstep_pkg::SEQ_DONE:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                    seq_next = tmstep_pkg::SEQ_IDLE;
            end
            default:
            begin
                seq_next = tmstep_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        mstate_next = mstate_reg;
        ones_next   = ones_reg;
        if (do_step)
        begin
            head_next   = part[1] ? head_inc : head_dec;
            mstate_next = part[4:2];
            if (part[0] && !rd_data_reg)
                ones_next = ones_reg + 1'b1;
            else if (!part[0] && rd_data_reg)
                ones_next = ones_reg - 1'b1;
        end
        else if (cfg_valid && cfg_index == tmstep_pkg::REG_START_STATE)
        begin
            mstate_next = cfg_data[tmstep_pkg::STATE_W-1:0];
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = head_reg;
        mem_wdata = part[0];
        if (seq_reg == tmstep_pkg::SEQ_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 1'b0;
        end
        else if (do_step)
        begin
            mem_we = 1'b1;
        end
    end

    // in a step head_next never equals the cell being written, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tape_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= tape_mem[head_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_reg <= tmstep_pkg::SEQ_CLEAR;
        else
            seq_reg <= seq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg    <= '0;
            head_reg   <= tmstep_pkg::HEAD_RESET;
            mstate_reg <= tmstep_pkg::START_RESET;
            ones_reg   <= '0;
            remain_reg <= '0;
            for (int i = 0; i < tmstep_pkg::NUM_RULES; i++)
                rule_reg[i] <= tmstep_pkg::RULE_RESET[i];
        end
        else
        begin
            if (seq_reg == tmstep_pkg::SEQ_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            head_reg   <= head_next;
            mstate_reg <= mstate_next;
            ones_reg   <= ones_next;
            remain_reg <= remain_next;
            if (cfg_valid)
            begin
                for (int i = 0; i < tmstep_pkg::NUM_RULES; i++)
                    if (cfg_index == tmstep_pkg::CFG_IW'(i))
                        rule_reg[i] <= cfg_data;
            end
        end
    end

    assign ones_wide     = 32'(ones_reg);
    assign ones_count    = (ones_wide > 32'(tmstep_pkg::COUNT_MAX)) ?
                           tmstep_pkg::COUNT_MAX : ones_wide[tmstep_pkg::COUNT_W-1:0];
    assign machine_state = mstate_reg;
    assign head_position = tmstep_pkg::POS_W'(head_reg);

endmodule
